// ===== src/fmmp_pkg.sv =====
package fmmp_pkg;

    localparam int unsigned INDEX_W = 32;
    localparam int unsigned OUT_W = 11;
    localparam int unsigned INDEX_BITS = 32;
    localparam int unsigned MODULUS = 2025;

    localparam int unsigned RES_W = $clog2(MODULUS);
    localparam int unsigned PROD_W = 2 * RES_W;
    localparam int unsigned SUM_W = PROD_W + 1;
    localparam int unsigned QUO_W = SUM_W - RES_W + 1;
    localparam int unsigned RECIP_W = SUM_W - RES_W + 2;
    localparam longint unsigned RECIP = (64'd1 << SUM_W) / MODULUS;

    localparam int unsigned PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_WAIT_IN = 3'd0;
    localparam pc_t PC_TEST = 3'd1;
    localparam pc_t PC_QUO = 3'd2;
    localparam pc_t PC_UPD = 3'd3;
    localparam pc_t PC_EMIT = 3'd4;

    typedef enum logic [1:0] {
        WAIT_NONE = 2'd0,
        WAIT_IN = 2'd1,
        WAIT_OUT = 2'd2
    } wait_sel_t;

    typedef enum logic [1:0] {
        JMP_NEVER = 2'd0,
        JMP_ALWAYS = 2'd1,
        JMP_N_ZERO = 2'd2
    } jmp_sel_t;

    typedef struct packed {
        logic load;
        logic sum_en;
        logic quo_en;
        logic upd_en;
        logic emit;
        wait_sel_t wait_sel;
        jmp_sel_t jmp_sel;
        pc_t jmp_addr;
    } ctrl_t;

    typedef struct packed {
        logic load;
        logic sum_en;
        logic quo_en;
        logic upd_en;
    } dp_ctrl_t;

    typedef logic [RES_W-1:0] res_t;

endpackage

// ===== src/fmmp_ucode_rom.sv =====
module fmmp_ucode_rom (
    input  fmmp_pkg::pc_t   pc,
    output fmmp_pkg::ctrl_t cw
);

    always_comb
    begin
        cw = '0;
        cw.wait_sel = fmmp_pkg::WAIT_NONE;
        cw.jmp_sel = fmmp_pkg::JMP_NEVER;
        cw.jmp_addr = fmmp_pkg::PC_WAIT_IN;
        case (pc)
            fmmp_pkg::PC_WAIT_IN:
            begin
                cw.load = 1'b1;
                cw.wait_sel = fmmp_pkg::WAIT_IN;
            end
            fmmp_pkg::PC_TEST:
            begin
                cw.sum_en = 1'b1;
                cw.jmp_sel = fmmp_pkg::JMP_N_ZERO;
                cw.jmp_addr = fmmp_pkg::PC_EMIT;
            end
            fmmp_pkg::PC_QUO:
            begin
                cw.quo_en = 1'b1;
            end
            fmmp_pkg::PC_UPD:
            begin
                cw.upd_en = 1'b1;
                cw.jmp_sel = fmmp_pkg::JMP_ALWAYS;
                cw.jmp_addr = fmmp_pkg::PC_TEST;
            end
            fmmp_pkg::PC_EMIT:
            begin
                cw.emit = 1'b1;
                cw.wait_sel = fmmp_pkg::WAIT_OUT;
                cw.jmp_sel = fmmp_pkg::JMP_ALWAYS;
                cw.jmp_addr = fmmp_pkg::PC_WAIT_IN;
            end
            default:
            begin
                cw.jmp_sel = fmmp_pkg::JMP_ALWAYS;
                cw.jmp_addr = fmmp_pkg::PC_WAIT_IN;
            end
        endcase
    end

endmodule

// ===== src/fmmp_dot.sv =====
module fmmp_dot (
    input  logic           clk,
    input  logic           sum_en,
    input  logic           quo_en,
    input  fmmp_pkg::res_t a,
    input  fmmp_pkg::res_t b,
    input  fmmp_pkg::res_t c,
    input  fmmp_pkg::res_t d,
    output fmmp_pkg::res_t residue
);

    localparam int unsigned QP_W = fmmp_pkg::SUM_W + fmmp_pkg::RECIP_W;

    logic [fmmp_pkg::PROD_W-1:0] prod_ab;
    logic [fmmp_pkg::PROD_W-1:0] prod_cd;
    logic [fmmp_pkg::SUM_W-1:0] sum_next;
    logic [fmmp_pkg::SUM_W-1:0] sum_reg;
    logic [fmmp_pkg::SUM_W-1:0] sum2_reg;
    logic [QP_W-1:0] quo_prod;
    logic [fmmp_pkg::QUO_W-1:0] quo_next;
    logic [fmmp_pkg::QUO_W-1:0] quo_reg;
    logic [fmmp_pkg::SUM_W-1:0] quo_mod;
    logic [fmmp_pkg::SUM_W-1:0] rem;

    assign prod_ab = fmmp_pkg::PROD_W'(a) * fmmp_pkg::PROD_W'(b);
    assign prod_cd = fmmp_pkg::PROD_W'(c) * fmmp_pkg::PROD_W'(d);
    assign sum_next = fmmp_pkg::SUM_W'(prod_ab) + fmmp_pkg::SUM_W'(prod_cd);

    assign quo_prod = QP_W'(sum_reg) * QP_W'(fmmp_pkg::RECIP);
    assign quo_next = fmmp_pkg::QUO_W'(quo_prod >> fmmp_pkg::SUM_W);

    assign quo_mod = fmmp_pkg::SUM_W'(fmmp_pkg::SUM_W'(quo_reg)
                                      * fmmp_pkg::SUM_W'(fmmp_pkg::MODULUS));
    assign rem = sum2_reg - quo_mod;

    always_comb
    begin
        if (rem >= fmmp_pkg::SUM_W'(fmmp_pkg::MODULUS))
        begin
            residue = fmmp_pkg::RES_W'(rem - fmmp_pkg::SUM_W'(fmmp_pkg::MODULUS));
        end
        else
        begin
            residue = fmmp_pkg::RES_W'(rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (quo_en)
        begin
            quo_reg <= quo_next;
            sum2_reg <= sum_reg;
        end
    end

endmodule

// ===== src/fmmp_datapath.sv =====
module fmmp_datapath (
    input  logic                           clk,
    input  fmmp_pkg::dp_ctrl_t             ctrl,
    input  logic [fmmp_pkg::INDEX_W-1:0]   index,
    output logic                           n_zero,
    output fmmp_pkg::res_t                 fib
);

    fmmp_pkg::res_t acc_reg [4];
    fmmp_pkg::res_t pw_reg [4];
    fmmp_pkg::res_t acc_prod [4];
    fmmp_pkg::res_t pw_prod [4];
    logic [fmmp_pkg::INDEX_BITS-1:0] n_reg;

    genvar gi;
    generate
        for (gi = 0; gi < 4; gi++)
        begin : g_entry
            fmmp_dot u_acc_dot (
                .clk     (clk),
                .sum_en  (ctrl.sum_en),
                .quo_en  (ctrl.quo_en),
                .a       (acc_reg[2 * (gi / 2)]),
                .b       (pw_reg[gi % 2]),
                .c       (acc_reg[2 * (gi / 2) + 1]),
                .d       (pw_reg[2 + (gi % 2)]),
                .residue (acc_prod[gi])
            );

            fmmp_dot u_pw_dot (
                .clk     (clk),
                .sum_en  (ctrl.sum_en),
                .quo_en  (ctrl.quo_en),
                .a       (pw_reg[2 * (gi / 2)]),
                .b       (pw_reg[gi % 2]),
                .c       (pw_reg[2 * (gi / 2) + 1]),
                .d       (pw_reg[2 + (gi % 2)]),
                .residue (pw_prod[gi])
            );
        end
    endgenerate

    assign n_zero = (n_reg == '0);
    assign fib = acc_reg[1];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            acc_reg[0] <= fmmp_pkg::res_t'(1);
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            acc_reg[3] <= fmmp_pkg::res_t'(1);
            pw_reg[0] <= fmmp_pkg::res_t'(1);
            pw_reg[1] <= fmmp_pkg::res_t'(1);
            pw_reg[2] <= fmmp_pkg::res_t'(1);
            pw_reg[3] <= '0;
            n_reg <= fmmp_pkg::INDEX_BITS'(index);
        end
        else if (ctrl.upd_en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pw_reg[i] <= pw_prod[i];
                if (n_reg[0])
                begin
                    acc_reg[i] <= acc_prod[i];
                end
            end
            n_reg <= n_reg >> 1;
        end
    end

endmodule

// ===== src/fibonacci_mod_matrix_power.sv =====
// Each accepted word makes L passes before its result word, where L is
// the position of the highest set bit of the index plus one (zero for a zero index).
// No new word is taken until its result is emitted, and an output stall holds the emit step;
// each index bit costs one three-step pass through the modular dot-product units.
// Reset: rst_n clears the step counter and the output valid; matrix registers need none.
module fibonacci_mod_matrix_power (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         index_valid,
    output logic                         index_stall,
    input  logic [fmmp_pkg::INDEX_W-1:0] index,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [fmmp_pkg::OUT_W-1:0]   fib_residue
);

    fmmp_pkg::pc_t pc_reg;
    fmmp_pkg::pc_t pc_next;
    fmmp_pkg::ctrl_t cw;
    fmmp_pkg::dp_ctrl_t dp_ctrl;
    logic stay;
    logic take;
    logic out_blocked;
    logic n_zero;
    fmmp_pkg::res_t fib;
    logic result_valid_reg;
    logic result_valid_next;
    logic [fmmp_pkg::OUT_W-1:0] fib_residue_reg;
    logic emit_go;

    fmmp_ucode_rom u_rom (
        .pc (pc_reg),
        .cw (cw)
    );

    assign out_blocked = result_valid_reg & result_stall;

    always_comb
    begin
        case (cw.wait_sel)
            fmmp_pkg::WAIT_IN:  stay = ~index_valid;
            fmmp_pkg::WAIT_OUT: stay = out_blocked;
            default:            stay = 1'b0;
        endcase
        case (cw.jmp_sel)
            fmmp_pkg::JMP_ALWAYS: take = 1'b1;
            fmmp_pkg::JMP_N_ZERO: take = n_zero;
            default:              take = 1'b0;
        endcase
        if (stay)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = cw.jmp_addr;
        end
        else
        begin
            pc_next = pc_reg + fmmp_pkg::pc_t'(1);
        end
    end

    assign index_stall = ~cw.load;

    always_comb
    begin
        dp_ctrl.load = cw.load & ~stay;
        dp_ctrl.sum_en = cw.sum_en & ~stay;
        dp_ctrl.quo_en = cw.quo_en & ~stay;
        dp_ctrl.upd_en = cw.upd_en & ~stay;
    end

    fmmp_datapath u_dp (
        .clk    (clk),
        .ctrl   (dp_ctrl),
        .index  (index),
        .n_zero (n_zero),
        .fib    (fib)
    );

    assign emit_go = cw.emit & ~stay;

    always_comb
    begin
        if (emit_go)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= fmmp_pkg::PC_WAIT_IN;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            fib_residue_reg <= fmmp_pkg::OUT_W'(fib);
        end
    end

    assign result_valid = result_valid_reg;
    assign fib_residue = fib_residue_reg;

`ifndef SYNTHESIS
    a_stall_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        !index_stall |-> pc_reg == fmmp_pkg::PC_WAIT_IN)
        else $error("input taken outside the wait step");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == fmmp_pkg::PC_EMIT && !out_blocked) |=> result_valid)
        else $error("emitted word not presented");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> 32'(fib_residue) < fmmp_pkg::MODULUS)
        else $error("residue out of range");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= fmmp_pkg::PC_EMIT)
        else $error("step counter out of program");
`endif

endmodule
